// File: rtl/core/ant_colony_task_scheduler_assert.svh
// Assertion macros for the ant colony task scheduler.
// Used by rtl/core/ant_colony_task_scheduler.sv; define ASSERT_OFF to compile them out.
// Clock aclk and reset aresetn are taken from the including module.
`ifndef ANT_COLONY_TASK_SCHEDULER_ASSERT_SVH
`define ANT_COLONY_TASK_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked outside reset
`define ACS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ant colony scheduler: assertion failed");
// Checked at every rising edge, reset included
`define ACS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("ant colony scheduler: assertion failed");
`else
`define ACS_ASSERT(label, prop)
`define ACS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/core/acts_pkg.sv
// Package for the ant colony task scheduler: codes, widths, types, FSM states.
// No dependencies; imported by acts_div, ant_colony_task_scheduler and the testbench.
package acts_pkg;

    localparam int ACTS_NUM_TASKS = 8;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_MAX  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_INIT = 8'd3;

    // Configuration reset values
    localparam logic [15:0] EVAP_RST    = 16'd52429;
    localparam logic [15:0] GAIN_RST    = 16'd6554;
    localparam logic [15:0] PH_MAX_RST  = 16'd32768;
    localparam logic [15:0] PH_INIT_RST = 16'd16384;

    // Divider and datapath widths
    localparam int DIV_N_W    = 24;
    localparam int DIV_D_W    = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W);
    localparam int WEIGHT_W   = 20;
    localparam int SUCC_SHIFT = 14;
    localparam logic [15:0] UTIL_SAT   = 16'hFFFF;
    localparam logic [15:0] UTIL_LIMIT = 16'd32768;

    typedef struct packed {
        logic [7:0]  period;
        logic [7:0]  run;
        logic [7:0]  remain;
        logic [15:0] rel;
        logic [15:0] pher;
    } task_entry_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REL_RD,
        ST_REL_DIV,
        ST_REL_WAIT,
        ST_CHK,
        ST_W_RD,
        ST_W_DIV,
        ST_W_WAIT,
        ST_SORT,
        ST_T_RD,
        ST_T_DIV,
        ST_T_WAIT,
        ST_SC_WALK,
        ST_SC_DIV,
        ST_SC_WAIT,
        ST_SEL1,
        ST_SEL2,
        ST_DEP_MUL,
        ST_DEP_SCAN,
        ST_DEP_DIV,
        ST_DEP_WAIT,
        ST_RUN_SCAN,
        ST_RUN_WB,
        ST_OUT
    } state_t;

endpackage

// File: rtl/core/acts_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on acts_pkg (div_req_t, div_rsp_t, widths).
module acts_div import acts_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;
    logic [DIV_D_W:0]     rem_next;

    // Trial subtract of the next partial remainder
    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_N_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= rem_next[DIV_D_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/core/ant_colony_task_scheduler.sv
// Channel  Dir  Handshake            Payload
// s_       in   s_valid / s_ready    s_operation, s_task_slot, s_period_ticks, s_run_ticks
// m_       out  m_valid / m_ready    m_ran_valid, m_ran_task, m_job_done, m_rescheduled,
//                                    m_tick_time
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A load item is written to the RAM from the idle state. Every release test, weight,
// utilisation term, deposit share and each rotation score that starts on an active
// task is computed on the shared divider (start, 24 shifts, done).
// Reset is synchronous, active low, and needs no clearing pass.
// A tick result waits in the output register; the next item is taken meanwhile.
// Task state sits in one synchronous RAM; depends on acts_pkg and acts_div.
`include "ant_colony_task_scheduler_assert.svh"

module ant_colony_task_scheduler import acts_pkg::*; #(
    parameter int NUM_TASKS = ACTS_NUM_TASKS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [2:0]           s_task_slot,
    input  logic [7:0]           s_period_ticks,
    input  logic [7:0]           s_run_ticks,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_ran_valid,
    output logic [2:0]           m_ran_task,
    output logic                 m_job_done,
    output logic                 m_rescheduled,
    output logic [15:0]          m_tick_time,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int SLOT_W  = $clog2(NUM_TASKS);
    localparam int CNT_W   = $clog2(NUM_TASKS + 1);
    localparam int SCORE_W = CNT_W + SUCC_SHIFT;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_TASKS - 1);

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] evap_reg, gain_reg, phmax_reg, phinit_reg;

    // Control state
    logic [15:0]          time_reg;
    logic [NUM_TASKS-1:0] loaded_reg;
    logic [NUM_TASKS-1:0] active_reg;
    logic [SLOT_W-1:0]    rank_reg [NUM_TASKS];
    logic [SLOT_W-1:0]    k_reg, start_reg, pass_reg;
    logic [SLOT_W-1:0]    best_reg, secd_reg;
    logic [CNT_W-1:0]     r_reg;
    logic                 dep_sel_reg, second_reg, released_reg, last_done_reg;
    logic                 resched_reg, ran_reg, done_reg;
    logic [SLOT_W-1:0]    ran_slot_reg;

    // Working data
    logic [WEIGHT_W-1:0]  wgt_reg   [NUM_TASKS];
    logic [15:0]          term_reg  [NUM_TASKS];
    logic [SCORE_W-1:0]   score_reg [NUM_TASKS];
    logic [15:0]          acc_reg;
    logic [CNT_W-1:0]     succ_reg, fail_reg;
    logic [SCORE_W-1:0]   bestv_reg, secv_reg, share_reg;
    logic [15:0]          evp_reg;

    // Task RAM
    task_entry_t          mem [NUM_TASKS];
    task_entry_t          mem_rdata_reg;
    logic                 mem_re, mem_we;
    logic [SLOT_W-1:0]    mem_raddr, mem_waddr;
    task_entry_t          mem_wdata;

    // Output register
    logic                 m_valid_reg, m_ran_valid_reg, m_job_done_reg, m_resched_reg;
    logic [2:0]           m_ran_task_reg;
    logic [15:0]          m_tick_time_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    acts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Walk position and the task at that rank
    logic [SLOT_W:0]   pos_sum;
    logic [SLOT_W-1:0] pos, cur_slot, load_slot;
    logic              cur_act, last_k, last_start, last_pass, slot_ok, out_free;

    always_comb begin
        pos_sum    = {1'b0, start_reg} + {1'b0, k_reg};
        pos        = (pos_sum >= (SLOT_W + 1)'(NUM_TASKS)) ?
                     SLOT_W'(pos_sum - (SLOT_W + 1)'(NUM_TASKS)) : SLOT_W'(pos_sum);
        cur_slot   = rank_reg[pos];
        cur_act    = active_reg[cur_slot];
        last_k     = (k_reg == LAST_IDX);
        last_start = (start_reg == LAST_IDX);
        last_pass  = (pass_reg == LAST_IDX);
        load_slot  = SLOT_W'(s_task_slot);
        slot_ok    = ({2'b00, s_task_slot} < 5'(NUM_TASKS));
        out_free   = !m_valid_reg || m_ready;
    end

    // Arithmetic around the divider
    logic [15:0]         deadline_gap;
    logic [WEIGHT_W-1:0] ph10;
    logic                rel_hit;
    logic [16:0]         acc_sum;
    logic [15:0]         acc_new;
    logic [SCORE_W-1:0]  dep_score;
    logic [WEIGHT_W-1:0] dep_sum;
    logic [15:0]         dep_ph;

    always_comb begin
        deadline_gap = mem_rdata_reg.rel + {8'd0, mem_rdata_reg.period} - time_reg;
        ph10      = WEIGHT_W'(mem_rdata_reg.pher) * WEIGHT_W'(10);
        rel_hit   = loaded_reg[pos] && (mem_rdata_reg.period != 8'd0)
                    && (div_rsp.remainder == '0);
        acc_sum   = {1'b0, acc_reg} + {1'b0, term_reg[pos]};
        acc_new   = acc_sum[16] ? UTIL_SAT : acc_sum[15:0];
        dep_score = dep_sel_reg ? secv_reg : bestv_reg;
        dep_sum   = WEIGHT_W'(evp_reg) + div_rsp.quotient[WEIGHT_W-1:0];
        dep_ph    = (dep_sum > WEIGHT_W'(phmax_reg)) ? phmax_reg : dep_sum[15:0];
    end

    // One pass of odd-even transposition sort, descending and stable
    logic [SLOT_W-1:0]   rank_sw [NUM_TASKS];
    logic [WEIGHT_W-1:0] wgt_sw  [NUM_TASKS];

    always_comb begin
        rank_sw = rank_reg;
        wgt_sw  = wgt_reg;
        for (int p = 0; p < NUM_TASKS - 1; p++) begin
            if (((p % 2) == int'(pass_reg[0])) && (wgt_reg[p] < wgt_reg[p+1])) begin
                rank_sw[p]   = rank_reg[p+1];
                rank_sw[p+1] = rank_reg[p];
                wgt_sw[p]    = wgt_reg[p+1];
                wgt_sw[p+1]  = wgt_reg[p];
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_operation == OP_TICK) state_next = ST_REL_RD;
            end
            ST_REL_RD:  state_next = ST_REL_DIV;
            ST_REL_DIV: state_next = ST_REL_WAIT;
            ST_REL_WAIT: begin
                if (div_rsp.done) state_next = last_k ? ST_CHK : ST_REL_RD;
            end
            ST_CHK: state_next = (released_reg || last_done_reg) ? ST_W_RD : ST_RUN_SCAN;
            ST_W_RD:  state_next = ST_W_DIV;
            ST_W_DIV: state_next = ST_W_WAIT;
            ST_W_WAIT: begin
                if (div_rsp.done) state_next = last_k ? ST_SORT : ST_W_RD;
            end
            ST_SORT: begin
                if (last_pass) state_next = second_reg ? ST_RUN_SCAN : ST_T_RD;
            end
            ST_T_RD:  state_next = ST_T_DIV;
            ST_T_DIV: state_next = ST_T_WAIT;
            ST_T_WAIT: begin
                if (div_rsp.done) state_next = last_k ? ST_SC_WALK : ST_T_RD;
            end
            ST_SC_WALK: begin
                if (k_reg == '0 && !cur_act) begin
                    if (last_start) state_next = ST_SEL1;
                end else if (last_k) begin
                    state_next = ST_SC_DIV;
                end
            end
            ST_SC_DIV: state_next = ST_SC_WAIT;
            ST_SC_WAIT: begin
                if (div_rsp.done) state_next = last_start ? ST_SEL1 : ST_SC_WALK;
            end
            ST_SEL1: begin
                if (last_k) state_next = ST_SEL2;
            end
            ST_SEL2: begin
                if (last_k) state_next = ST_DEP_MUL;
            end
            ST_DEP_MUL: state_next = ST_DEP_SCAN;
            ST_DEP_SCAN: begin
                if (cur_act) state_next = ST_DEP_DIV;
                else if (last_k) state_next = dep_sel_reg ? ST_W_RD : ST_DEP_MUL;
            end
            ST_DEP_DIV: state_next = ST_DEP_WAIT;
            ST_DEP_WAIT: begin
                if (div_rsp.done) begin
                    if (last_k) state_next = dep_sel_reg ? ST_W_RD : ST_DEP_MUL;
                    else state_next = ST_DEP_SCAN;
                end
            end
            ST_RUN_SCAN: begin
                if (cur_act) state_next = ST_RUN_WB;
                else if (last_k) state_next = ST_OUT;
            end
            ST_RUN_WB: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM and divider controls
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = cur_slot;
        mem_we    = 1'b0;
        mem_waddr = cur_slot;
        mem_wdata = mem_rdata_reg;
        div_req   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mem_we           = s_valid && (s_operation == OP_LOAD) && slot_ok;
                mem_waddr        = load_slot;
                mem_wdata.period = s_period_ticks;
                mem_wdata.run    = s_run_ticks;
                mem_wdata.remain = '0;
                mem_wdata.rel    = '0;
                mem_wdata.pher   = phinit_reg;
            end
            ST_REL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = pos;
            end
            ST_REL_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(time_reg);
                div_req.divisor  = (mem_rdata_reg.period != 8'd0) ?
                                   DIV_D_W'(mem_rdata_reg.period) : DIV_D_W'(1);
            end
            ST_REL_WAIT: begin
                mem_we           = div_rsp.done && rel_hit;
                mem_waddr        = pos;
                mem_wdata.remain = mem_rdata_reg.run;
                mem_wdata.rel    = time_reg;
            end
            ST_W_RD, ST_T_RD: mem_re = 1'b1;
            ST_W_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(ph10);
                div_req.divisor  = (deadline_gap != 16'd0) ? deadline_gap : DIV_D_W'(1);
            end
            ST_T_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'({mem_rdata_reg.run, 15'd0});
                div_req.divisor  = (mem_rdata_reg.period != 8'd0) ?
                                   DIV_D_W'(mem_rdata_reg.period) : DIV_D_W'(1);
            end
            ST_SC_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'({succ_reg, {SUCC_SHIFT{1'b0}}});
                div_req.divisor  = DIV_D_W'(fail_reg) + DIV_D_W'(1);
            end
            ST_DEP_SCAN, ST_RUN_SCAN: mem_re = cur_act;
            ST_DEP_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(share_reg);
                div_req.divisor  = DIV_D_W'(r_reg);
            end
            ST_DEP_WAIT: begin
                mem_we         = div_rsp.done;
                mem_wdata.pher = dep_ph;
            end
            ST_RUN_WB: begin
                mem_we           = 1'b1;
                mem_wdata.remain = (mem_rdata_reg.remain <= 8'd1) ?
                                   8'd0 : mem_rdata_reg.remain - 8'd1;
            end
            default: ;
        endcase
    end

    // Task RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            evap_reg        <= EVAP_RST;
            gain_reg        <= GAIN_RST;
            phmax_reg       <= PH_MAX_RST;
            phinit_reg      <= PH_INIT_RST;
            time_reg        <= '0;
            loaded_reg      <= '0;
            active_reg      <= '0;
            for (int i = 0; i < NUM_TASKS; i++) rank_reg[i] <= SLOT_W'(i);
            k_reg           <= '0;
            start_reg       <= '0;
            pass_reg        <= '0;
            r_reg           <= '0;
            dep_sel_reg     <= 1'b0;
            second_reg      <= 1'b0;
            released_reg    <= 1'b0;
            last_done_reg   <= 1'b0;
            resched_reg     <= 1'b0;
            ran_reg         <= 1'b0;
            done_reg        <= 1'b0;
            ran_slot_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_EVAP:    evap_reg   <= cfg_data;
                    CFG_GAIN:    gain_reg   <= cfg_data;
                    CFG_PH_MAX:  phmax_reg  <= cfg_data;
                    CFG_PH_INIT: phinit_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Result register: set by a finished tick, cleared when taken
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_operation == OP_LOAD) begin
                            if (slot_ok) begin
                                loaded_reg[load_slot] <= 1'b1;
                                active_reg[load_slot] <= 1'b0;
                            end
                        end else begin
                            k_reg        <= '0;
                            start_reg    <= '0;
                            released_reg <= 1'b0;
                            resched_reg  <= 1'b0;
                            ran_reg      <= 1'b0;
                            done_reg     <= 1'b0;
                            ran_slot_reg <= '0;
                        end
                    end
                end
                ST_REL_WAIT: begin
                    if (div_rsp.done) begin
                        if (rel_hit) begin
                            active_reg[pos] <= 1'b1;
                            released_reg    <= 1'b1;
                        end
                        k_reg <= last_k ? '0 : k_reg + 1'b1;
                    end
                end
                ST_CHK: begin
                    if (released_reg || last_done_reg) begin
                        resched_reg <= 1'b1;
                        second_reg  <= 1'b0;
                    end
                end
                ST_W_WAIT, ST_T_WAIT: begin
                    if (div_rsp.done) begin
                        k_reg    <= last_k ? '0 : k_reg + 1'b1;
                        pass_reg <= '0;
                    end
                end
                ST_SORT: begin
                    rank_reg <= rank_sw;
                    pass_reg <= pass_reg + 1'b1;
                end
                ST_SC_WALK: begin
                    if (k_reg == '0 && !cur_act) begin
                        start_reg <= last_start ? '0 : start_reg + 1'b1;
                    end else if (!last_k) begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_SC_WAIT: begin
                    if (div_rsp.done) begin
                        k_reg     <= '0;
                        start_reg <= last_start ? '0 : start_reg + 1'b1;
                    end
                end
                ST_SEL1: k_reg <= last_k ? '0 : k_reg + 1'b1;
                ST_SEL2: begin
                    k_reg <= last_k ? '0 : k_reg + 1'b1;
                    if (last_k) dep_sel_reg <= 1'b0;
                end
                ST_DEP_MUL: begin
                    start_reg <= dep_sel_reg ? secd_reg : best_reg;
                    k_reg     <= '0;
                    r_reg     <= CNT_W'(1);
                end
                ST_DEP_SCAN: begin
                    if (!cur_act) begin
                        if (last_k) begin
                            k_reg <= '0;
                            if (dep_sel_reg) begin
                                start_reg  <= '0;
                                second_reg <= 1'b1;
                            end
                            dep_sel_reg <= 1'b1;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_DEP_WAIT: begin
                    if (div_rsp.done) begin
                        r_reg <= r_reg + 1'b1;
                        if (last_k) begin
                            k_reg <= '0;
                            if (dep_sel_reg) begin
                                start_reg  <= '0;
                                second_reg <= 1'b1;
                            end
                            dep_sel_reg <= 1'b1;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_RUN_SCAN: begin
                    if (cur_act) begin
                        ran_reg      <= 1'b1;
                        ran_slot_reg <= cur_slot;
                    end else if (!last_k) begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_RUN_WB: begin
                    if (mem_rdata_reg.remain <= 8'd1) begin
                        active_reg[cur_slot] <= 1'b0;
                        done_reg             <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        time_reg      <= time_reg + 16'd1;
                        last_done_reg <= done_reg;
                        k_reg         <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working data and result payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_W_WAIT: begin
                if (div_rsp.done)
                    wgt_reg[pos] <= cur_act ? div_rsp.quotient[WEIGHT_W-1:0] : '0;
            end
            ST_SORT: wgt_reg <= wgt_sw;
            ST_T_WAIT: begin
                if (div_rsp.done) begin
                    if (mem_rdata_reg.period == 8'd0 || div_rsp.quotient[DIV_N_W-1:16] != '0)
                        term_reg[pos] <= UTIL_SAT;
                    else
                        term_reg[pos] <= div_rsp.quotient[15:0];
                end
                acc_reg   <= '0;
                succ_reg  <= '0;
                fail_reg  <= '0;
                bestv_reg <= '0;
                best_reg  <= '0;
                secv_reg  <= '0;
                secd_reg  <= '0;
            end
            ST_SC_WALK: begin
                if (k_reg == '0 && !cur_act) begin
                    score_reg[start_reg] <= '0;
                end else if (cur_act) begin
                    acc_reg <= acc_new;
                    if (acc_new <= UTIL_LIMIT) succ_reg <= succ_reg + 1'b1;
                    else fail_reg <= fail_reg + 1'b1;
                end
            end
            ST_SC_WAIT: begin
                if (div_rsp.done) begin
                    score_reg[start_reg] <= div_rsp.quotient[SCORE_W-1:0];
                    acc_reg  <= '0;
                    succ_reg <= '0;
                    fail_reg <= '0;
                end
            end
            ST_SEL1: begin
                if (score_reg[pos] > bestv_reg) begin
                    bestv_reg <= score_reg[pos];
                    best_reg  <= k_reg;
                end
            end
            ST_SEL2: begin
                if (k_reg != best_reg && score_reg[pos] > secv_reg) begin
                    secv_reg <= score_reg[pos];
                    secd_reg <= k_reg;
                end
            end
            ST_DEP_MUL: share_reg <= SCORE_W'(({dep_score, 16'd0} >> 16) * gain_reg >> 16);
            ST_DEP_DIV: evp_reg <= 16'((32'(mem_rdata_reg.pher) * 32'(evap_reg)) >> 16);
            ST_OUT: begin
                if (out_free) begin
                    m_ran_valid_reg <= ran_reg;
                    m_ran_task_reg  <= 3'(ran_slot_reg);
                    m_job_done_reg  <= done_reg;
                    m_resched_reg   <= resched_reg;
                    m_tick_time_reg <= time_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_ran_valid   = m_ran_valid_reg;
    assign m_ran_task    = m_ran_task_reg;
    assign m_job_done    = m_job_done_reg;
    assign m_rescheduled = m_resched_reg;
    assign m_tick_time   = m_tick_time_reg;

    // Checks
    `ACS_ASSERT(a_active_is_loaded, (active_reg & ~loaded_reg) == '0)
    `ACS_ASSERT(a_ram_no_overlap, !(mem_we && mem_re))
    `ACS_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy)
    `ACS_ASSERT(a_out_time_step, m_valid_reg |-> (time_reg == m_tick_time_reg + 16'd1))
    `ACS_ASSERT(a_done_needs_run, (m_valid_reg && m_job_done_reg) |-> m_ran_valid_reg)

endmodule

// File: tb/ant_colony_task_scheduler_checker.sv
// Checker for the ant colony task scheduler: watches the item, result and
// register channels, predicts each tick result and compares it field by field.
// Depends on acts_pkg for the task count, operation codes, register indexes and reset values.
module ant_colony_task_scheduler_checker import acts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_operation,
    input  logic [2:0]           s_task_slot,
    input  logic [7:0]           s_period_ticks,
    input  logic [7:0]           s_run_ticks,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_ran_valid,
    input  logic [2:0]           m_ran_task,
    input  logic                 m_job_done,
    input  logic                 m_rescheduled,
    input  logic [15:0]          m_tick_time,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = ACTS_NUM_TASKS;

    typedef struct packed {
        logic        ran_valid;
        logic [2:0]  ran_task;
        logic        job_done;
        logic        rescheduled;
        logic [15:0] tick_time;
    } tick_result_t;

    // Shadow copy of the registers and task table
    logic [15:0] evap, gain, ph_max, ph_init;
    logic [15:0] clock_now;
    logic [7:0]  per [NT];
    logic [7:0]  runt [NT];
    logic [7:0]  remain [NT];
    logic [15:0] rel [NT];
    logic        active [NT];
    logic        loaded [NT];
    logic [15:0] pher [NT];
    logic [2:0]  order [NT];
    logic        just_done;

    tick_result_t expected_ticks[$];

    // Stable insertion sort of the rank order by urgency weight, descending
    function automatic void rank_by_weight();
        logic [31:0] w [NT];
        logic [15:0] d;
        logic [2:0]  key;
        int q;
        for (int s = 0; s < NT; s++) begin
            w[s] = 0;
            if (active[s]) begin
                d = rel[s] + 16'(per[s]) - clock_now;
                w[s] = (32'(pher[s]) * 10) / ((d == 0) ? 32'd1 : 32'(d));
            end
        end
        for (int p = 1; p < NT; p++) begin
            key = order[p];
            q = p;
            while (q > 0 && w[order[q-1]] < w[key]) begin
                order[q] = order[q-1];
                q--;
            end
            order[q] = key;
        end
    endfunction

    // Success/failure score of the rotation starting at one rank position
    function automatic logic [31:0] rotation_score(int start);
        logic [31:0] acc, succ, fl, term;
        int s;
        acc = 0; succ = 0; fl = 0;
        if (!active[order[start]]) return 0;
        for (int k = 0; k < NT; k++) begin
            s = order[(start + k) % NT];
            if (active[s]) begin
                term = (per[s] != 0) ? ((32'(runt[s]) << 15) / 32'(per[s])) : 32'd65535;
                acc += term;
                if (acc > 65535) acc = 65535;
                if (acc <= 32768) succ++;
                else fl++;
            end
        end
        return (succ << 14) / (fl + 1);
    endfunction

    // Evaporate and deposit along a rotation; share falls off with active rank
    function automatic void lay_pheromone(logic [31:0] score, int start);
        logic [63:0] share, v;
        logic [31:0] r;
        int s;
        share = (64'(score) * 64'(gain)) >> 16;
        r = 1;
        for (int k = 0; k < NT; k++) begin
            s = order[(start + k) % NT];
            if (active[s]) begin
                v = ((64'(pher[s]) * 64'(evap)) >> 16) + share / 64'(r);
                if (v > 64'(ph_max)) v = 64'(ph_max);
                pher[s] = v[15:0];
                r++;
            end
        end
    endfunction

    function automatic void reschedule_tasks();
        logic [31:0] sc [NT];
        logic [31:0] bestv, secv;
        int best, secd;
        bestv = 0; secv = 0; best = 0; secd = 0;
        rank_by_weight();
        for (int i = 0; i < NT; i++) sc[i] = rotation_score(i);
        for (int i = 0; i < NT; i++)
            if (sc[i] > bestv) begin
                bestv = sc[i];
                best = i;
            end
        lay_pheromone(bestv, best);
        for (int i = 0; i < NT; i++)
            if (i != best && sc[i] > secv) begin
                secv = sc[i];
                secd = i;
            end
        lay_pheromone(secv, secd);
        rank_by_weight();
    endfunction

    // One tick: release, optional reschedule, run one unit of the top task
    function automatic tick_result_t schedule_tick();
        tick_result_t res;
        logic released;
        int s;
        res = '0;
        released = 0;
        res.tick_time = clock_now;
        for (int i = 0; i < NT; i++)
            if (loaded[i] && per[i] != 0 && (clock_now % 16'(per[i])) == 0) begin
                rel[i] = clock_now;
                active[i] = 1;
                remain[i] = runt[i];
                released = 1;
            end
        if (released || just_done) begin
            reschedule_tasks();
            res.rescheduled = 1;
        end
        for (int p = 0; p < NT; p++) begin
            s = order[p];
            if (active[s]) begin
                res.ran_valid = 1;
                res.ran_task = 3'(s);
                if (remain[s] <= 1) begin
                    remain[s] = 0;
                    active[s] = 0;
                    res.job_done = 1;
                end else begin
                    remain[s]--;
                end
                break;
            end
        end
        just_done = res.job_done;
        clock_now++;
        return res;
    endfunction

    // Channel monitor: compare results, track registers, predict on items
    always @(posedge aclk) begin
        tick_result_t want, got;
        if (!aresetn) begin
            evap = EVAP_RST; gain = GAIN_RST; ph_max = PH_MAX_RST; ph_init = PH_INIT_RST;
            clock_now = 0;
            just_done = 0;
            for (int i = 0; i < NT; i++) begin
                per[i] = 0; runt[i] = 0; remain[i] = 0; rel[i] = 0;
                active[i] = 0; loaded[i] = 0; pher[i] = 0; order[i] = 3'(i);
            end
            expected_ticks.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_ran_valid, m_ran_task, m_job_done, m_rescheduled, m_tick_time};
                if (expected_ticks.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.ran_valid !== want.ran_valid) begin
                        $display("%0t: ran_valid exp %0d got %0d", $time,
                                 want.ran_valid, got.ran_valid);
                        fail_count++;
                    end
                    if (got.ran_task !== want.ran_task) begin
                        $display("%0t: ran_task exp %0d got %0d", $time,
                                 want.ran_task, got.ran_task);
                        fail_count++;
                    end
                    if (got.job_done !== want.job_done) begin
                        $display("%0t: job_done exp %0d got %0d", $time,
                                 want.job_done, got.job_done);
                        fail_count++;
                    end
                    if (got.rescheduled !== want.rescheduled) begin
                        $display("%0t: rescheduled exp %0d got %0d", $time,
                                 want.rescheduled, got.rescheduled);
                        fail_count++;
                    end
                    if (got.tick_time !== want.tick_time) begin
                        $display("%0t: tick_time exp %0d got %0d", $time,
                                 want.tick_time, got.tick_time);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EVAP:    evap = cfg_data;
                    CFG_GAIN:    gain = cfg_data;
                    CFG_PH_MAX:  ph_max = cfg_data;
                    CFG_PH_INIT: ph_init = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_LOAD) begin
                    per[s_task_slot] = s_period_ticks;
                    runt[s_task_slot] = s_run_ticks;
                    pher[s_task_slot] = ph_init;
                    loaded[s_task_slot] = 1;
                    active[s_task_slot] = 0;
                    remain[s_task_slot] = 0;
                    rel[s_task_slot] = 0;
                end else begin
                    expected_ticks.push_back(schedule_tick());
                end
            end
        end
        // Results still owed to the stimulus side
        pending = expected_ticks.size();
    end
endmodule

// File: tb/ant_colony_task_scheduler_tb.sv
// Testbench top for the ant colony task scheduler: clock, reset, stimulus,
// watchdog and verdict. Depends on acts_pkg, the block and the checker module.
module ant_colony_task_scheduler_tb import acts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;
    localparam int IDLE_LIMIT = 40000;
    localparam int SETTLE     = 200;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0, s_ready;
    logic                 s_operation = OP_TICK;
    logic [2:0]           s_task_slot = 0;
    logic [7:0]           s_period_ticks = 0, s_run_ticks = 0;
    logic                 m_valid, m_ready = 0;
    logic                 m_ran_valid, m_job_done, m_rescheduled;
    logic [2:0]           m_ran_task;
    logic [15:0]          m_tick_time;
    logic                 cfg_valid = 0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [15:0]          cfg_data = 0;
    int                   fail_count, pending;
    int                   idle_cycles = 0;
    logic                 quiet = 0;   // no idling on either side while set

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    ant_colony_task_scheduler dut (.*);
    ant_colony_task_scheduler_checker chk (.*);

    // Watchdog: cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[ant_colony_task_scheduler] ERROR");
            $finish;
        end
    end

    // Result side: random stall before each result
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(logic op, logic [2:0] slot, logic [7:0] prd, logic [7:0] run);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_task_slot <= slot;
        s_period_ticks <= prd;
        s_run_ticks <= run;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // Block idle: every result back, then time for a trailing load
    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_load();
        logic [7:0] prd, run;
        case ($urandom_range(0, 9))
            0:       prd = 0;
            1:       prd = 8'($urandom_range(0, 255));
            default: prd = 8'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0:       run = 0;
            1:       run = 8'($urandom_range(0, 255));
            default: run = 8'($urandom_range(1, 6));
        endcase
        send_item(OP_LOAD, 3'($urandom_range(0, 7)), prd, run);
    endtask

    initial begin
        logic [15:0] regs [4];
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: zero period, zero run time, extreme fields, idle ticks
        send_item(OP_TICK, 3'd0, 8'd0, 8'd0);
        send_item(OP_LOAD, 3'd0, 8'd4, 8'd1);
        send_item(OP_LOAD, 3'd1, 8'd8, 8'd3);
        send_item(OP_LOAD, 3'd7, 8'd255, 8'd255);
        send_item(OP_LOAD, 3'd2, 8'd0, 8'd5);
        send_item(OP_LOAD, 3'd3, 8'd3, 8'd0);
        send_item(OP_LOAD, 3'd4, 8'd1, 8'd1);
        for (int i = 0; i < 16; i++) send_item(OP_TICK, 3'(i), 8'hAA, 8'h55);
        drain();

        // Phases of register settings, extremes first
        for (int ph = 0; ph < 10; ph++) begin
            for (int r = 0; r < 4; r++)
                case (ph)
                    0:       regs[r] = 16'h0000;
                    1:       regs[r] = 16'hFFFF;
                    2:       regs[r] = (r == 0) ? 16'hFFFF : 16'h0000;
                    3:       regs[r] = (r == 0) ? 16'h0000 : 16'hFFFF;
                    default: regs[r] = 16'($urandom);
                endcase
            write_reg(CFG_EVAP, regs[0]);
            write_reg(CFG_GAIN, regs[1]);
            write_reg(CFG_PH_MAX, regs[2]);
            write_reg(CFG_PH_INIT, regs[3]);
            write_reg(CFG_UNUSED, 16'($urandom));
            quiet = (ph % 4 == 3);
            for (int i = 0; i < 128; i++) begin
                if (i == 64 && ph == 5) begin
                    // Sender holds off until every result is back
                    s_valid <= 0;
                    do @(posedge aclk); while (pending != 0);
                end
                if ($urandom_range(0, 99) < 18) random_load();
                else send_item(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end
        quiet = 0;

        if (fail_count == 0)
            $display("[ant_colony_task_scheduler] OK");
        else
            $display("[ant_colony_task_scheduler] ERROR");
        $finish;
    end
endmodule
